FILE: rtl/mcst_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mcst_pkg: shared types and constants of the cursor speed tracker
// Widths of the datapath, reset values, register indexes and the control
// structs that pass between the top level and its serial arithmetic units.
// ---------------------------------------------------------------------------
package mcst_pkg;

  localparam int POS_W  = 10;
  localparam int SPD_W  = 16;
  localparam int DT_W   = 32;
  localparam int DLT_W  = 8;
  localparam int CFG_W  = 16;
  localparam int SQ_W   = 2 * POS_W;
  localparam int D2_W   = SQ_W + 1;
  localparam int ROOT_W = 21;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int CNT_W  = $clog2(ROOT_W);

  // One second squared in milliseconds: scales the squared distance.
  localparam logic [19:0] MS_SQ = 20'd1_000_000;

  localparam logic [POS_W-1:0] RST_X_MAX       = 10'd239;
  localparam logic [POS_W-1:0] RST_Y_MAX       = 10'd134;
  localparam logic [SPD_W-1:0] RST_SPEED_LIMIT = 16'd1000;
  localparam logic [POS_W-1:0] HOME_X          = 10'd120;
  localparam logic [POS_W-1:0] HOME_Y          = 10'd67;

  localparam int BTN_LEFT   = 0;
  localparam int BTN_RIGHT  = 1;
  localparam int BTN_MIDDLE = 2;

  typedef enum logic [1:0] {
    CFG_X_MAX       = 2'd0,
    CFG_Y_MAX       = 2'd1,
    CFG_SPEED_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic start;
  } mcst_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mcst_sts_t;

endpackage

`default_nettype wire

FILE: rtl/mcst_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mcst_if: valid/ready channels of the cursor speed tracker
// One interface for the tick channel and one for the result channel.
// ---------------------------------------------------------------------------
interface mcst_in_if;
  logic              valid;
  logic              ready;
  logic              has_report;
  logic [7:0]        button_bits;
  logic signed [7:0] delta_x;
  logic signed [7:0] delta_y;
  logic [31:0]       now_ms;

  modport source (output valid, has_report, button_bits, delta_x, delta_y, now_ms,
                  input ready);
  modport sink (input valid, has_report, button_bits, delta_x, delta_y, now_ms,
                output ready);
endinterface

interface mcst_out_if;
  logic        valid;
  logic        ready;
  logic        left_pressed;
  logic        right_pressed;
  logic        middle_pressed;
  logic [9:0]  cursor_col;
  logic [9:0]  cursor_row;
  logic [15:0] speed_px_s;

  modport source (output valid, left_pressed, right_pressed, middle_pressed,
                  cursor_col, cursor_row, speed_px_s, input ready);
  modport sink (input valid, left_pressed, right_pressed, middle_pressed,
                cursor_col, cursor_row, speed_px_s, output ready);
endinterface

`default_nettype wire

FILE: rtl/mcst_isqrt.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mcst_isqrt: digit-serial integer square root
// Restoring square root that takes two radicand bits and yields one root
// bit per cycle.
// ---------------------------------------------------------------------------
module mcst_isqrt
  import mcst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mcst_ctl_t        ctl,
  input  wire logic [RAD_W-1:0] radicand,
  output mcst_sts_t             sts,
  output logic [ROOT_W-1:0]     root
);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r, rem_nxt, rem_sh, trial;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNT_W'(ROOT_W - 1);
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = root_r;

endmodule

`default_nettype wire

FILE: rtl/mcst_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mcst_div: bit-serial restoring divider
// Divides the root by the elapsed time, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mcst_div
  import mcst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mcst_ctl_t         ctl,
  input  wire logic [ROOT_W-1:0] dividend,
  input  wire logic [DT_W-1:0]   divisor,
  output mcst_sts_t              sts,
  output logic [ROOT_W-1:0]      quotient
);

  logic [ROOT_W-1:0] q_r, q_nxt;
  logic [DT_W-1:0]   dvs_r;
  logic [DT_W-1:0]   rem_r, rem_nxt;
  logic [DT_W:0]     rem_sh, diff;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[ROOT_W-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DT_W-1:0] : rem_sh[DT_W-1:0];
    q_nxt   = {q_r[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q_r   <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      cnt_r <= CNT_W'(ROOT_W - 1);
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

FILE: rtl/mouse_cursor_speed_tracker_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mouse_cursor_speed_tracker_top: cursor position and speed from mouse ticks
// Latches buttons, moves and clamps the cursor, and reports the speed in
// pixels per second through a serial square root and a serial divider.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake       Payload
//   in_ch     sink       valid / ready   has_report, button_bits, delta_x,
//                                        delta_y, now_ms
//   out_ch    source     valid / ready   left/right/middle_pressed,
//                                        cursor_col, cursor_row, speed_px_s
//   cfg_*     sink       cfg_wr_en only  cfg_index, cfg_data
//
// When time has passed, a tick's time from acceptance to result is set
// mostly by the square root and the divider, which each produce one bit
// of a 21-bit result per cycle and run one after the other; a tick with zero
// elapsed time skips both units.
// Only one tick is in flight; in_ch.ready is high while the sequencer idles.
// The result register keeps a finished transaction while out_ch is stalled,
// so the next tick is accepted meanwhile and waits only at its own result.
// Reset is synchronous and active low; it restores the register defaults,
// centers the cursor, releases the buttons and zeroes the speed.
// ---------------------------------------------------------------------------
module mouse_cursor_speed_tracker_top
  import mcst_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  mcst_in_if.sink               in_ch,
  mcst_out_if.source            out_ch,
  input  wire logic             cfg_wr_en,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_SCALE,
    S_ROOT,
    S_DIV,
    S_OUT
  } state_t;

  // Configuration registers.
  logic [POS_W-1:0] x_max_r, y_max_r;
  logic [SPD_W-1:0] speed_limit_r;

  // Tracker state.
  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [POS_W-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [DT_W-1:0]  prev_time_r, prev_time_nxt;
  logic [SPD_W-1:0] speed_r, speed_nxt;
  logic [2:0]       btn_r, btn_nxt;

  // Per-tick working registers.
  logic [DT_W-1:0]  now_r, now_nxt, dt_r, dt_nxt;
  logic [SQ_W-1:0]  sq_x_r, sq_x_nxt, sq_y_r, sq_y_nxt;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic             sq_start_r, sq_start_nxt;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_btn_r, out_btn_nxt;
  logic [POS_W-1:0] out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic [SPD_W-1:0] out_spd_r, out_spd_nxt;

  logic [POS_W:0]   dx, dy;
  logic [POS_W-1:0] abs_x, abs_y;
  logic [D2_W-1:0]  d2;
  logic [ROOT_W-1:0] root, quot;
  logic              in_acc, out_free;

  mcst_ctl_t sq_ctl, dv_ctl;
  mcst_sts_t sq_sts, dv_sts;

  // Moves one axis by a signed delta and clamps it to 0..hi.
  function automatic logic [POS_W-1:0] clamp_axis(input logic [POS_W-1:0] pos,
                                                   input logic [DLT_W-1:0] delta,
                                                   input logic [POS_W-1:0] hi);
    logic signed [POS_W+1:0] sum;
    sum = $signed({2'b00, pos}) + $signed({{(POS_W+2-DLT_W){delta[DLT_W-1]}}, delta});
    if (sum[POS_W+1]) begin
      clamp_axis = '0;
    end else if (sum[POS_W:0] > {1'b0, hi}) begin
      clamp_axis = hi;
    end else begin
      clamp_axis = sum[POS_W-1:0];
    end
  endfunction

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // The axis moves since the previous tick, folded to magnitudes for squaring.
  always_comb begin
    dx    = {1'b0, pos_x_r} - {1'b0, prev_x_r};
    dy    = {1'b0, pos_y_r} - {1'b0, prev_y_r};
    abs_x = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    abs_y = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    d2    = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  end

  always_comb begin
    state_nxt     = state_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    prev_time_nxt = prev_time_r;
    speed_nxt     = speed_r;
    btn_nxt       = btn_r;
    now_nxt       = now_r;
    dt_nxt        = dt_r;
    sq_x_nxt      = sq_x_r;
    sq_y_nxt      = sq_y_r;
    rad_nxt       = rad_r;
    sq_start_nxt  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_btn_nxt   = out_btn_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_spd_nxt   = out_spd_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.has_report) begin
            btn_nxt   = {in_ch.button_bits[BTN_MIDDLE], in_ch.button_bits[BTN_RIGHT],
                         in_ch.button_bits[BTN_LEFT]};
            pos_x_nxt = clamp_axis(pos_x_r, in_ch.delta_x, x_max_r);
            pos_y_nxt = clamp_axis(pos_y_r, in_ch.delta_y, y_max_r);
          end
          now_nxt   = in_ch.now_ms;
          dt_nxt    = in_ch.now_ms - prev_time_r;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        sq_x_nxt  = SQ_W'(abs_x) * SQ_W'(abs_x);
        sq_y_nxt  = SQ_W'(abs_y) * SQ_W'(abs_y);
        // With no time elapsed the speed is held, so the arithmetic is skipped.
        state_nxt = (dt_r == '0) ? S_OUT : S_SCALE;
      end
      S_SCALE: begin
        rad_nxt      = RAD_W'(d2) * RAD_W'(MS_SQ);
        sq_start_nxt = 1'b1;
        state_nxt    = S_ROOT;
      end
      S_ROOT: begin
        if (sq_sts.done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (dv_sts.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          if (dt_r != '0) begin
            if (quot > {{(ROOT_W-SPD_W){1'b0}}, speed_limit_r}) begin
              speed_nxt = speed_limit_r;
            end else begin
              speed_nxt = quot[SPD_W-1:0];
            end
          end
          prev_x_nxt    = pos_x_r;
          prev_y_nxt    = pos_y_r;
          prev_time_nxt = now_r;
          out_valid_nxt = 1'b1;
          out_btn_nxt   = btn_r;
          out_col_nxt   = pos_x_r;
          out_row_nxt   = pos_y_r;
          out_spd_nxt   = speed_nxt;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, architectural state and the configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pos_x_r       <= HOME_X;
      pos_y_r       <= HOME_Y;
      prev_x_r      <= HOME_X;
      prev_y_r      <= HOME_Y;
      prev_time_r   <= '0;
      speed_r       <= '0;
      btn_r         <= '0;
      sq_start_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      x_max_r       <= RST_X_MAX;
      y_max_r       <= RST_Y_MAX;
      speed_limit_r <= RST_SPEED_LIMIT;
    end else begin
      state_r     <= state_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      prev_time_r <= prev_time_nxt;
      speed_r     <= speed_nxt;
      btn_r       <= btn_nxt;
      sq_start_r  <= sq_start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_X_MAX:       x_max_r       <= cfg_data[POS_W-1:0];
          CFG_Y_MAX:       y_max_r       <= cfg_data[POS_W-1:0];
          CFG_SPEED_LIMIT: speed_limit_r <= cfg_data[SPD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    dt_r      <= dt_nxt;
    sq_x_r    <= sq_x_nxt;
    sq_y_r    <= sq_y_nxt;
    rad_r     <= rad_nxt;
    out_btn_r <= out_btn_nxt;
    out_col_r <= out_col_nxt;
    out_row_r <= out_row_nxt;
    out_spd_r <= out_spd_nxt;
  end

  assign sq_ctl.start = sq_start_r;
  assign dv_ctl.start = (state_r == S_ROOT) && sq_sts.done;

  mcst_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sq_ctl),
    .radicand (rad_r),
    .sts      (sq_sts),
    .root     (root)
  );

  mcst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dv_ctl),
    .dividend (root),
    .divisor  (dt_r),
    .sts      (dv_sts),
    .quotient (quot)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_pressed   = out_btn_r[BTN_LEFT];
  assign out_ch.right_pressed  = out_btn_r[BTN_RIGHT];
  assign out_ch.middle_pressed = out_btn_r[BTN_MIDDLE];
  assign out_ch.cursor_col     = out_col_r;
  assign out_ch.cursor_row     = out_row_r;
  assign out_ch.speed_px_s     = out_spd_r;

`ifndef ASSERT_OFF
  // While waiting on the root, the square root unit is starting, working or finishing.
  a_root_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> (sq_ctl.start || sq_sts.busy || sq_sts.done))
    else $error("square root unit idle while the sequencer waits on it");

  // The divider is never started when no time has elapsed.
  a_div_dt: assert property (@(posedge clk) disable iff (!rst_n)
    dv_ctl.start |-> (dt_r != '0))
    else $error("divider started with zero elapsed time");

  // An accepted tick closes the input until its result is loaded.
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("second tick accepted while one is in flight");

  // A new result appears only from the result stage of the sequencer.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the result stage");
`endif

endmodule

`default_nettype wire
